[sv/vcrt_pkg.sv]
package vcrt_pkg;

   localparam logic [7:0] CSR_BPP_RESET = 8'd3;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_BAD_PIXEL     = 3'd1,
      STATUS_SIZE_MISMATCH = 3'd2,
      STATUS_LATE          = 3'd3,
      STATUS_OUT_OF_BOUNDS = 3'd4,
      STATUS_TRUNCATED     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_AREA,
      ST_MUL_SIZE,
      ST_JUDGE
   } state_type;

   typedef struct packed {
      logic [31:0] frame_id;
      logic [15:0] width_px;
      logic [15:0] height_px;
      logic [7:0]  pixel_bytes;
      logic [31:0] total_bytes;
      logic [31:0] chunk_offset;
      logic [15:0] chunk_bytes;
      logic [15:0] payload_avail;
   } req_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic mul_area;
      logic mul_size;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

[sv/vcrt_ifs.sv]
interface vcrt_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vcrt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] frame_id;
   logic [15:0] width_px;
   logic [15:0] height_px;
   logic [7:0]  pixel_bytes;
   logic [31:0] total_bytes;
   logic [31:0] chunk_offset;
   logic [15:0] chunk_bytes;
   logic [15:0] payload_avail;
   modport source (output valid, output frame_id, output width_px, output height_px,
                   output pixel_bytes, output total_bytes, output chunk_offset,
                   output chunk_bytes, output payload_avail, input ready);
   modport sink (input valid, input frame_id, input width_px, input height_px,
                 input pixel_bytes, input total_bytes, input chunk_offset,
                 input chunk_bytes, input payload_avail, output ready);
endinterface

interface vcrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] write_offset;
   logic [15:0] write_len;
   logic        frame_done;
   logic [15:0] done_width;
   logic [15:0] done_height;
   logic [63:0] delivered_count;
   logic [63:0] dropped_count;
   modport source (output valid, output status, output write_offset, output write_len,
                   output frame_done, output done_width, output done_height,
                   output delivered_count, output dropped_count, input ready);
   modport sink (input valid, input status, input write_offset, input write_len,
                 input frame_done, input done_width, input done_height,
                 input delivered_count, input dropped_count, output ready);
endinterface

[sv/vcrt_ctrl.sv]
module vcrt_ctrl
   import vcrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL_AREA;
         end
         ST_MUL_AREA: state_in = ST_MUL_SIZE;
         ST_MUL_SIZE: state_in = ST_JUDGE;
         ST_JUDGE: begin
            // hold until the output register can take the result
            if (!dp_status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_MUL_AREA: cmd.mul_area = 1'b1;
         ST_MUL_SIZE: cmd.mul_size = 1'b1;
         ST_JUDGE:    cmd.commit   = !dp_status.rsp_busy;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[sv/vcrt_dpath.sv]
module vcrt_dpath
   import vcrt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [7:0]      csr_data,
   input  req_payload_type req_data,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   dp_status,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic [2:0]      rsp_status,
   output logic [31:0]     rsp_write_offset,
   output logic [15:0]     rsp_write_len,
   output logic            rsp_frame_done,
   output logic [15:0]     rsp_done_width,
   output logic [15:0]     rsp_done_height,
   output logic [63:0]     rsp_delivered_count,
   output logic [63:0]     rsp_dropped_count
);

   logic [7:0]      bpp_cfg_ff;
   req_payload_type req_ff;
   logic [31:0]     area_ff;
   logic [39:0]     size_ff;
   logic [32:0]     end_ff;

   // frame tracking state
   logic [31:0] cur_frame_ff, cur_frame_in;
   logic [31:0] cur_size_ff, cur_size_in;
   logic [32:0] rcvd_ff, rcvd_in;
   logic [15:0] cur_width_ff, cur_width_in;
   logic [15:0] cur_height_ff, cur_height_in;
   logic        open_ff, open_in;
   logic        delivered_ff, delivered_in;
   logic [63:0] deliv_total_ff, deliv_total_in;
   logic [63:0] drop_total_ff, drop_total_in;
   logic [15:0] last_width_ff, last_width_in;
   logic [15:0] last_height_ff, last_height_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [31:0] wr_off_ff;
   logic [15:0] wr_len_ff;
   logic        done_ff, done_in;

   logic        new_frame;
   logic [32:0] rcvd_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_cfg_ff <= CSR_BPP_RESET;
      end else if (csr_we) begin
         bpp_cfg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.mul_area) begin
         area_ff <= {16'b0, req_ff.width_px} * {16'b0, req_ff.height_px};
         end_ff  <= {1'b0, req_ff.chunk_offset} + {17'b0, req_ff.chunk_bytes};
      end
      if (cmd.mul_size) size_ff <= {8'b0, area_ff} * {32'b0, req_ff.pixel_bytes};
   end

   assign new_frame = !open_ff || (req_ff.frame_id != cur_frame_ff)
                      || (cur_size_ff != req_ff.total_bytes);
   assign rcvd_sum  = (new_frame ? 33'd0 : rcvd_ff) + {17'b0, req_ff.chunk_bytes};

   always_comb begin
      cur_frame_in   = cur_frame_ff;
      cur_size_in    = cur_size_ff;
      rcvd_in        = rcvd_ff;
      cur_width_in   = cur_width_ff;
      cur_height_in  = cur_height_ff;
      open_in        = open_ff;
      delivered_in   = delivered_ff;
      deliv_total_in = deliv_total_ff;
      drop_total_in  = drop_total_ff;
      last_width_in  = last_width_ff;
      last_height_in = last_height_ff;
      done_in        = 1'b0;
      status_in      = STATUS_OK;

      if (req_ff.pixel_bytes != bpp_cfg_ff) begin
         status_in = STATUS_BAD_PIXEL;
      end else if (req_ff.total_bytes == 32'd0
                   || size_ff != {8'b0, req_ff.total_bytes}) begin
         status_in = STATUS_SIZE_MISMATCH;
      end else begin
         // open a new frame; an unfinished old one counts as dropped
         if (new_frame) begin
            if (open_ff && !delivered_ff) drop_total_in = drop_total_ff + 64'd1;
            cur_frame_in  = req_ff.frame_id;
            cur_size_in   = req_ff.total_bytes;
            cur_width_in  = req_ff.width_px;
            cur_height_in = req_ff.height_px;
            rcvd_in       = 33'd0;
            delivered_in  = 1'b0;
            open_in       = 1'b1;
         end
         if (!new_frame && delivered_ff) begin
            status_in = STATUS_LATE;
         end else if (req_ff.chunk_bytes == 16'd0 || end_ff > {1'b0, req_ff.total_bytes}) begin
            status_in = STATUS_OUT_OF_BOUNDS;
         end else if (req_ff.payload_avail < req_ff.chunk_bytes) begin
            status_in = STATUS_TRUNCATED;
         end else begin
            rcvd_in = rcvd_sum;
            if (rcvd_sum >= {1'b0, req_ff.total_bytes}) begin
               deliv_total_in = deliv_total_ff + 64'd1;
               delivered_in   = 1'b1;
               last_width_in  = new_frame ? req_ff.width_px : cur_width_ff;
               last_height_in = new_frame ? req_ff.height_px : cur_height_ff;
               done_in        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_frame_ff   <= '0;
         cur_size_ff    <= '0;
         rcvd_ff        <= '0;
         cur_width_ff   <= '0;
         cur_height_ff  <= '0;
         open_ff        <= 1'b0;
         delivered_ff   <= 1'b0;
         deliv_total_ff <= '0;
         drop_total_ff  <= '0;
         last_width_ff  <= '0;
         last_height_ff <= '0;
      end else if (cmd.commit) begin
         cur_frame_ff   <= cur_frame_in;
         cur_size_ff    <= cur_size_in;
         rcvd_ff        <= rcvd_in;
         cur_width_ff   <= cur_width_in;
         cur_height_ff  <= cur_height_in;
         open_ff        <= open_in;
         delivered_ff   <= delivered_in;
         deliv_total_ff <= deliv_total_in;
         drop_total_ff  <= drop_total_in;
         last_width_ff  <= last_width_in;
         last_height_ff <= last_height_in;
      end
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         wr_off_ff <= (status_in == STATUS_OK) ? req_ff.chunk_offset : 32'd0;
         wr_len_ff <= (status_in == STATUS_OK) ? req_ff.chunk_bytes : 16'd0;
         done_ff   <= done_in;
      end
   end

   assign dp_status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_write_offset    = wr_off_ff;
   assign rsp_write_len       = wr_len_ff;
   assign rsp_frame_done      = done_ff;
   assign rsp_done_width      = last_width_ff;
   assign rsp_done_height     = last_height_ff;
   assign rsp_delivered_count = deliv_total_ff;
   assign rsp_dropped_count   = drop_total_ff;

endmodule

[sv/video_chunk_reassembly_tracker_unit.sv]
// Video chunk reassembly tracker.
// Channels: req_bus carries one parsed chunk header per request; rsp_bus
// returns exactly one result per request (status, frame buffer write offset
// and length, completion flag, last delivered frame size and the delivered
// and dropped frame totals). csr_bus writes the accepted bytes-per-pixel
// value; it is always ready and must only be written while the block is idle.
// Steps: the accepting cycle captures a request, then the width*height
// multiply, the area*pixel-size multiply, then judge and commit into the
// output register. A new request is accepted only in the idle state, so
// the block takes no new request until the last one has been committed.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, and the judge step holds until that register frees up.
// Reset: synchronous, active high. Clears frame tracking state and totals,
// empties the output register and sets bytes-per-pixel back to 3.
module video_chunk_reassembly_tracker_unit
   import vcrt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   vcrt_csr_if.sink   csr_bus,
   vcrt_req_if.sink   req_bus,
   vcrt_rsp_if.source rsp_bus
);

   req_payload_type req_data;
   ctrl_cmd_type    cmd;
   dp_status_type   dp_status;
   logic            req_ready;

   // config writes never stall
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   // gather the header fields into one request word
   assign req_data.frame_id      = req_bus.frame_id;
   assign req_data.width_px      = req_bus.width_px;
   assign req_data.height_px     = req_bus.height_px;
   assign req_data.pixel_bytes   = req_bus.pixel_bytes;
   assign req_data.total_bytes   = req_bus.total_bytes;
   assign req_data.chunk_offset  = req_bus.chunk_offset;
   assign req_data.chunk_bytes   = req_bus.chunk_bytes;
   assign req_data.payload_avail = req_bus.payload_avail;

   vcrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   vcrt_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_bus.valid),
      .csr_data            (csr_bus.data),
      .req_data            (req_data),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_status          (rsp_bus.status),
      .rsp_write_offset    (rsp_bus.write_offset),
      .rsp_write_len       (rsp_bus.write_len),
      .rsp_frame_done      (rsp_bus.frame_done),
      .rsp_done_width      (rsp_bus.done_width),
      .rsp_done_height     (rsp_bus.done_height),
      .rsp_delivered_count (rsp_bus.delivered_count),
      .rsp_dropped_count   (rsp_bus.dropped_count)
   );

endmodule
